### hw/rtl/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce block.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;

   localparam int FRACTION_WIDTH_DEF = 16;
   localparam int CALC_WIDTH         = 64;
   localparam int KIND_BITS          = 3;
   localparam int NUM_BITS           = 33;
   localparam int DEN_BITS           = 31;
   localparam int SHIFT_BITS         = 6;
   localparam int COUNT_BITS         = 6;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_P_REDUCED = 3'd0,
      KIND_Q_REDUCED = 3'd1,
      KIND_SUM       = 3'd2,
      KIND_DIFF      = 3'd3,
      KIND_PRODUCT   = 3'd4,
      KIND_QUOTIENT  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      MUL_AD = 2'd0,
      MUL_CB = 2'd1,
      MUL_BD = 2'd2,
      MUL_AC = 2'd3
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/rational_arith_reduce.sv
// Top level of the rational arithmetic reduce block: sequencer and shared datapath.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: four products through the shared multiplier, then for each of the six results a
// load step, a binary GCD and two restoring divisions, then a transfer; a result that is
// undefined or has a zero numerator goes from the load step straight to the transfer.
// Throughput: one item at a time; req_tready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
module rational_arith_reduce #(
   parameter int FRACTION_WIDTH = rar_pkg::FRACTION_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // From bit 0 up: p_numerator, p_denominator, q_numerator, q_denominator, zero pad.
   input  wire logic [((4*FRACTION_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // From bit 0 up: numerator (33 bits), denominator (31 bits).
   output logic [63:0]                                rsp_tdata,
   // From bit 0 up: result_kind (3 bits), undefined (1 bit).
   output logic [3:0]                                 rsp_tuser,
   output logic                                       rsp_tlast
);

   localparam int FW = FRACTION_WIDTH;
   localparam int CW = rar_pkg::CALC_WIDTH;

   // All values are carried as 64-bit two's complement words, so that products and sums
   // wrap exactly as a 64-bit machine word would at the widest fraction setting.

   rar_pkg::state_type                  state_ff, state_in;
   logic signed [FW-1:0]                a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [CW-1:0]                       ad_ff, ad_in, cb_ff, cb_in, bd_ff, bd_in, ac_ff, ac_in;
   logic [1:0]                          mul_sel_ff, mul_sel_in;
   logic [rar_pkg::KIND_BITS-1:0]       kind_ff, kind_in;
   logic [CW-1:0]                       nm_ff, nm_in, dm_ff, dm_in;
   logic [CW-1:0]                       x_ff, x_in, y_ff, y_in;
   logic [rar_pkg::SHIFT_BITS-1:0]      shift_ff, shift_in;
   logic [rar_pkg::COUNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [CW:0]                         rem_ff, rem_in;
   logic [CW-1:0]                       dvd_ff, dvd_in;
   logic [CW-1:0]                       qn_ff, qn_in;
   logic                                neg_ff, neg_in;
   logic [rar_pkg::NUM_BITS-1:0]        pnum_ff, pnum_in;
   logic [rar_pkg::DEN_BITS-1:0]        pden_ff, pden_in;
   logic                                pundef_ff, pundef_in;
   logic                                ovalid_ff, ovalid_in;
   logic [rar_pkg::NUM_BITS-1:0]        onum_ff, onum_in;
   logic [rar_pkg::DEN_BITS-1:0]        oden_ff, oden_in;
   logic [rar_pkg::KIND_BITS-1:0]       okind_ff, okind_in;
   logic                                oundef_ff, oundef_in;

   // Shared multiplier, one product per cycle.
   logic signed [FW-1:0]                mul_a, mul_b;
   logic signed [2*FW-1:0]              mul_prod;
   logic [CW-1:0]                       mul_ext;

   // Shared subtractor, used by the GCD compare and the division steps.
   logic [CW:0]                         sub_a, sub_b;
   logic [CW+1:0]                       sub_res;

   logic [CW-1:0]                       ld_num, ld_den, ld_nm, ld_dm, qd_neg;
   logic                                ld_undef;
   logic [CW:0]                         rem_sh;

   always_comb begin
      case (rar_pkg::mul_sel_type'(mul_sel_ff))
         rar_pkg::MUL_AD: begin mul_a = a_ff; mul_b = d_ff; end
         rar_pkg::MUL_CB: begin mul_a = c_ff; mul_b = b_ff; end
         rar_pkg::MUL_BD: begin mul_a = b_ff; mul_b = d_ff; end
         rar_pkg::MUL_AC: begin mul_a = a_ff; mul_b = c_ff; end
         default:         begin mul_a = a_ff; mul_b = d_ff; end
      endcase
      mul_prod = mul_a * mul_b;
      mul_ext  = CW'(mul_prod);
   end

   // Operands of the result now being worked on.
   always_comb begin
      case (rar_pkg::kind_type'(kind_ff))
         rar_pkg::KIND_P_REDUCED: begin
            ld_num = CW'(a_ff); ld_den = CW'(b_ff); ld_undef = (b_ff == '0);
         end
         rar_pkg::KIND_Q_REDUCED: begin
            ld_num = CW'(c_ff); ld_den = CW'(d_ff); ld_undef = (d_ff == '0);
         end
         rar_pkg::KIND_SUM: begin
            ld_num = ad_ff + cb_ff; ld_den = bd_ff;
            ld_undef = (b_ff == '0) || (d_ff == '0);
         end
         rar_pkg::KIND_DIFF: begin
            ld_num = ad_ff - cb_ff; ld_den = bd_ff;
            ld_undef = (b_ff == '0) || (d_ff == '0);
         end
         rar_pkg::KIND_PRODUCT: begin
            ld_num = ac_ff; ld_den = bd_ff;
            ld_undef = (b_ff == '0) || (d_ff == '0);
         end
         rar_pkg::KIND_QUOTIENT: begin
            ld_num = ad_ff; ld_den = cb_ff;
            ld_undef = (b_ff == '0) || (d_ff == '0) || (c_ff == '0);
         end
         default: begin
            ld_num = '0; ld_den = '0; ld_undef = 1'b1;
         end
      endcase
      ld_nm = ld_num[CW-1] ? (CW'(0) - ld_num) : ld_num;
      ld_dm = ld_den[CW-1] ? (CW'(0) - ld_den) : ld_den;
   end

   assign rem_sh = {rem_ff[CW-1:0], dvd_ff[CW-1]};

   always_comb begin
      if (state_ff == rar_pkg::ST_GCD) begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end else begin
         sub_a = rem_sh;
         sub_b = {1'b0, x_ff};
      end
      sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   end

   assign qd_neg = CW'(0) - qn_ff;

   always_comb begin
      state_in   = state_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      ad_in = ad_ff; cb_in = cb_ff; bd_in = bd_ff; ac_in = ac_ff;
      mul_sel_in = mul_sel_ff;
      kind_in    = kind_ff;
      nm_in = nm_ff; dm_in = dm_ff;
      x_in = x_ff; y_in = y_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      qn_in      = qn_ff;
      neg_in     = neg_ff;
      pnum_in = pnum_ff; pden_in = pden_ff; pundef_in = pundef_ff;
      ovalid_in  = ovalid_ff;
      onum_in = onum_ff; oden_in = oden_ff; okind_in = okind_ff; oundef_in = oundef_ff;

      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         rar_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               a_in       = req_tdata[FW-1:0];
               b_in       = req_tdata[2*FW-1:FW];
               c_in       = req_tdata[3*FW-1:2*FW];
               d_in       = req_tdata[4*FW-1:3*FW];
               mul_sel_in = 2'(rar_pkg::MUL_AD);
               kind_in    = rar_pkg::KIND_P_REDUCED;
               state_in   = rar_pkg::ST_MUL;
            end
         end
         rar_pkg::ST_MUL: begin
            case (rar_pkg::mul_sel_type'(mul_sel_ff))
               rar_pkg::MUL_AD: ad_in = mul_ext;
               rar_pkg::MUL_CB: cb_in = mul_ext;
               rar_pkg::MUL_BD: bd_in = mul_ext;
               rar_pkg::MUL_AC: ac_in = mul_ext;
               default:         ad_in = mul_ext;
            endcase
            mul_sel_in = mul_sel_ff + 2'd1;
            if (mul_sel_ff == 2'(rar_pkg::MUL_AC)) begin
               state_in = rar_pkg::ST_LOAD;
            end
         end
         rar_pkg::ST_LOAD: begin
            nm_in    = ld_nm;
            dm_in    = ld_dm;
            neg_in   = ld_num[CW-1] ^ ld_den[CW-1];
            x_in     = ld_nm;
            y_in     = ld_dm;
            shift_in = '0;
            if (ld_undef || (ld_den == '0)) begin
               pnum_in = '0; pden_in = '0; pundef_in = 1'b1;
               state_in = rar_pkg::ST_EMIT;
            end else if (ld_num == '0) begin
               pnum_in = '0; pden_in = rar_pkg::DEN_BITS'(1); pundef_in = 1'b0;
               state_in = rar_pkg::ST_EMIT;
            end else begin
               state_in = rar_pkg::ST_GCD;
            end
         end
         rar_pkg::ST_GCD: begin
            // Binary GCD: strip common twos, keep the larger odd value in x by a swap,
            // then replace it by the difference through the shared subtractor.
            if (y_ff == '0) begin
               x_in     = x_ff << shift_ff;
               rem_in   = '0;
               dvd_in   = nm_ff;
               cnt_in   = '0;
               state_in = rar_pkg::ST_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in     = x_ff >> 1;
               y_in     = y_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_res[CW+1]) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = y_ff;
               y_in = sub_res[CW-1:0];
            end
         end
         rar_pkg::ST_DIVN, rar_pkg::ST_DIVD: begin
            // Restoring division by the GCD held in x, one quotient bit a cycle.
            if (sub_res[CW+1]) begin
               rem_in = rem_sh;
               dvd_in = {dvd_ff[CW-2:0], 1'b0};
            end else begin
               rem_in = sub_res[CW:0];
               dvd_in = {dvd_ff[CW-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               cnt_in = '0;
               rem_in = '0;
               if (state_ff == rar_pkg::ST_DIVN) begin
                  qn_in    = dvd_in;
                  dvd_in   = dm_ff;
                  state_in = rar_pkg::ST_DIVD;
               end else begin
                  pnum_in   = neg_ff ? qd_neg[rar_pkg::NUM_BITS-1:0]
                                     : qn_ff[rar_pkg::NUM_BITS-1:0];
                  pden_in   = dvd_in[rar_pkg::DEN_BITS-1:0];
                  pundef_in = 1'b0;
                  state_in  = rar_pkg::ST_EMIT;
               end
            end
         end
         rar_pkg::ST_EMIT: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               onum_in   = pnum_ff;
               oden_in   = pden_ff;
               okind_in  = kind_ff;
               oundef_in = pundef_ff;
               if (kind_ff == rar_pkg::KIND_QUOTIENT) begin
                  state_in = rar_pkg::ST_IDLE;
               end else begin
                  kind_in  = kind_ff + 1'b1;
                  state_in = rar_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = rar_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rar_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      ad_ff <= ad_in; cb_ff <= cb_in; bd_ff <= bd_in; ac_ff <= ac_in;
      mul_sel_ff <= mul_sel_in;
      kind_ff    <= kind_in;
      nm_ff <= nm_in; dm_ff <= dm_in;
      x_ff <= x_in; y_ff <= y_in;
      shift_ff   <= shift_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      qn_ff      <= qn_in;
      neg_ff     <= neg_in;
      pnum_ff <= pnum_in; pden_ff <= pden_in; pundef_ff <= pundef_in;
      onum_ff <= onum_in; oden_ff <= oden_in; okind_ff <= okind_in; oundef_ff <= oundef_in;
   end

   assign req_tready = (state_ff == rar_pkg::ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {oden_ff, onum_ff};
   assign rsp_tuser  = {oundef_ff, okind_ff};
   assign rsp_tlast  = (okind_ff == rar_pkg::KIND_QUOTIENT);

endmodule
`default_nettype wire

### verif/rational_arith_reduce_tb.sv
// Self-checking testbench for the rational arithmetic reduce block.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_tb;

   localparam int FW        = 16;
   localparam int REQ_BITS  = ((4*FW+7)/8)*8;
   localparam int MAX_CYCLE = 5000000;

   typedef struct packed {
      rar_pkg::kind_type            kind;
      logic [rar_pkg::NUM_BITS-1:0] num;
      logic [rar_pkg::DEN_BITS-1:0] den;
      logic                         undef;
      logic                         last;
   } fraction_result_type;

   typedef struct {
      logic [FW-1:0] a, b, c, d;
      bit            typed;      // expected values written into the row below
      logic [rar_pkg::NUM_BITS-1:0] n0;   // P numerator
      logic [rar_pkg::DEN_BITS-1:0] d0;   // P denominator
      logic          u5;         // quotient undefined
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [63:0]         rsp_tdata;
   logic [3:0]          rsp_tuser;
   logic                rsp_tlast;

   fraction_result_type expected_results[$];
   int  error_count  = 0;
   int  cycle_count  = 0;
   bit  hold_off     = 1'b0;   // long receiver stall
   bit  quiet_phase  = 1'b0;   // stretch with no idling on either side

   rational_arith_reduce #(.FRACTION_WIDTH(FW)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Reduce num/den by the GCD and move the sign to the numerator.
   function automatic fraction_result_type reduce_fraction(rar_pkg::kind_type k, longint num,
                                                           longint den, bit undef);
      fraction_result_type r;
      longint unsigned nm, dm, x, y, t, sn;
      bit neg;
      r.kind = k;
      r.last = (k == rar_pkg::KIND_QUOTIENT);
      r.num = '0;
      r.den = '0;
      r.undef = 1'b1;
      if (!undef && den != 0) begin
         neg = (num < 0) != (den < 0);
         nm = (num < 0) ? -num : num;
         dm = (den < 0) ? -den : den;
         x = nm;
         y = dm;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         nm = nm / x;
         dm = dm / x;
         if (nm == 0) begin
            dm = 1;
            neg = 0;
         end
         sn = neg ? -nm : nm;
         r.num = sn[rar_pkg::NUM_BITS-1:0];
         r.den = dm[rar_pkg::DEN_BITS-1:0];
         r.undef = 1'b0;
      end
      return r;
   endfunction

   // Queue the six results for one pair of fractions P = a/b and Q = c/d.
   task automatic predict_fractions(logic [FW-1:0] ai, bi, ci, di);
      longint a, b, c, d;
      bit bz, dz;
      a = $signed(ai);
      b = $signed(bi);
      c = $signed(ci);
      d = $signed(di);
      bz = (b == 0);
      dz = (d == 0);
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_P_REDUCED, a, b, bz));
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_Q_REDUCED, c, d, dz));
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_SUM, a*d + c*b, b*d,
                                                 bz || dz));
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_DIFF, a*d - c*b, b*d,
                                                 bz || dz));
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_PRODUCT, a*c, b*d, bz || dz));
      expected_results.push_back(reduce_fraction(rar_pkg::KIND_QUOTIENT, a*d, c*b,
                                                 bz || dz || c == 0));
   endtask

   // Present one transfer on the request side, idling at random first.
   task automatic send_fractions(logic [FW-1:0] a, b, c, d);
      while (!quiet_phase && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {d, c, b, a};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_fractions(a, b, c, d);
      @(negedge clock);
   endtask

   function automatic logic [FW-1:0] rand_field();
      case ($urandom_range(7))
         0: return '0;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return FW'($signed($urandom_range(32)) - 16);
         4: return FW'($urandom_range(255)) << $urandom_range(8);
         default: return FW'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, except during the quiet stretch or the long hold-off.
   always @(negedge clock) begin
      rsp_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 25);
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      fraction_result_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d", rsp_tuser[2:0]);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tuser[2:0] !== exp_r.kind) begin
               $error("kind: expected %0d actual %0d", exp_r.kind, rsp_tuser[2:0]);
               error_count++;
            end
            if (rsp_tdata[rar_pkg::NUM_BITS-1:0] !== exp_r.num) begin
               $error("numerator: expected %h actual %h", exp_r.num, rsp_tdata[32:0]);
               error_count++;
            end
            if (rsp_tdata[63:rar_pkg::NUM_BITS] !== exp_r.den) begin
               $error("denominator: expected %h actual %h", exp_r.den, rsp_tdata[63:33]);
               error_count++;
            end
            if (rsp_tuser[3] !== exp_r.undef) begin
               $error("undefined: expected %0b actual %0b", exp_r.undef, rsp_tuser[3]);
               error_count++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("last_result: expected %0b actual %0b", exp_r.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (cycle_count >= MAX_CYCLE) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Long receiver hold-off, counted in cycles, while the sender keeps offering transfers.
   initial begin
      int n;
      wait (!reset);
      repeat (3000) @(posedge clock);
      @(negedge clock);
      hold_off = 1'b1;
      for (n = 0; n < 4000; n++) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      fraction_result_type head;
      int i;
      // Directed rows: extremes, zero denominators, zero numerators, sign cases.
      rows.push_back('{16'd1, 16'd2, 16'd1, 16'd3, 1, 33'd1, 31'd2, 1'b0});
      rows.push_back('{16'd0, 16'd5, 16'd3, 16'd4, 1, 33'd0, 31'd1, 1'b0});
      rows.push_back('{16'd7, 16'd0, 16'd3, 16'd4, 1, 33'd0, 31'd0, 1'b1});
      rows.push_back('{16'd7, 16'd9, 16'd3, 16'd0, 1, 33'd7, 31'd9, 1'b1});
      rows.push_back('{16'd7, 16'd9, 16'd0, 16'd4, 1, 33'd7, 31'd9, 1'b1});
      rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 33'd1, 31'd1, 1'b0});
      rows.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 33'd1, 31'd1, 1'b0});
      rows.push_back('{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0, '0, '0, 1'b0});
      rows.push_back('{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0, '0, '0, 1'b0});
      rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1, 33'd1, 31'd1, 1'b0});
      rows.push_back('{16'd3, 16'hFFFA, 16'hFFFD, 16'd6, 0, '0, '0, 1'b0});
      rows.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1, 33'd0, 31'd0, 1'b1});
      rows.push_back('{16'd1, 16'd2, 16'd1, 16'd2, 0, '0, '0, 1'b0});
      rows.push_back('{16'd12, 16'd18, 16'hFFF4, 16'h0012, 1, 33'd2, 31'd3, 1'b0});
      rows.push_back('{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0, '0, '0, 1'b0});
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[k]) begin
         r = rows[k];
         send_fractions(r.a, r.b, r.c, r.d);
         if (r.typed) begin
            // The queue holds this row's six results, P first and quotient last.
            head = expected_results[expected_results.size()-6];
            if (head.num !== r.n0 || head.den !== r.d0 ||
                expected_results[expected_results.size()-1].undef !== r.u5) begin
               $error("predictor: row %0d expected P %h/%h, undefined %0b", k,
                      r.n0, r.d0, r.u5);
               error_count++;
            end
         end
      end
      // Random part, with a stretch free of idling in the middle.
      for (i = 0; i < 145; i++) begin
         quiet_phase = (i >= 60 && i < 90);
         send_fractions(rand_field(), rand_field(), rand_field(), rand_field());
      end
      req_tvalid <= 1'b0;
      quiet_phase = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
